// File: rtl/core/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds the command codes, the per-cell control struct and both payload structs.
// No dependencies.
`default_nettype none

package dq_pkg;

	// Width of one stored word and of the count field on the result.
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 11;

	// Number of cells folded into one register of the back-value reduction.
	localparam int GROUP_SIZE = 32;

	// Command codes; unused codes behave as a peek.
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK       = 3'd4
	} cmd_t;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic en;
		cmd_t op;
	} cell_ctrl_t;

	// One command transaction.
	typedef struct packed {
		logic [2:0]               command;
		logic signed [WORD_W-1:0] push_value;
	} dq_in_t;

	// One result transaction.
	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic                     popped_valid;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
		logic                     overflow;
	} dq_out_t;

endpackage

`default_nettype wire

// File: rtl/core/dq_cell.sv
// One storage cell of the queue row: a word, an occupancy bit and a back tap.
// Takes a word from one of its two neighbors on a push or pop at the front.
// Depends on dq_pkg.
`default_nettype none

module dq_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire dq_pkg::cell_ctrl_t        ctrl,
	input  wire logic [dq_pkg::WORD_W-1:0] push_word,
	input  wire logic [dq_pkg::WORD_W-1:0] prev_data,
	input  wire logic                      prev_valid,
	input  wire logic [dq_pkg::WORD_W-1:0] next_data,
	input  wire logic                      next_valid,
	output logic      [dq_pkg::WORD_W-1:0] data,
	output logic                           valid,
	output logic      [dq_pkg::WORD_W-1:0] tap
);

	logic [dq_pkg::WORD_W-1:0] data_q;
	logic [dq_pkg::WORD_W-1:0] data_d;
	logic                      valid_q;
	logic                      valid_d;

	// Next contents: shift toward the back, fill the first free cell,
	// shift toward the front, or release the last occupied cell.
	always_comb begin
		data_d  = data_q;
		valid_d = valid_q;
		if (ctrl.en) begin
			unique case (ctrl.op)
				dq_pkg::CMD_PUSH_FRONT: begin
					data_d  = prev_data;
					valid_d = prev_valid;
				end
				dq_pkg::CMD_PUSH_BACK: begin
					if (!valid_q && prev_valid) begin
						data_d  = push_word;
						valid_d = 1'b1;
					end
				end
				dq_pkg::CMD_POP_FRONT: begin
					data_d  = next_data;
					valid_d = next_valid;
				end
				dq_pkg::CMD_POP_BACK: begin
					if (valid_q && !next_valid) begin
						valid_d = 1'b0;
					end
				end
				default: begin
					data_d  = data_q;
					valid_d = valid_q;
				end
			endcase
		end
	end

	// Occupancy is control state and is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// The stored word needs no reset.
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	// The last occupied cell offers its word to the back-value reduction.
	assign data  = data_q;
	assign valid = valid_q;
	assign tap   = (valid_q && !next_valid) ? data_q : '0;

endmodule

`default_nettype wire

// File: rtl/core/dq_group_or.sv
// Registered OR reduction over the back taps of one group of cells.
// At most one tap in the whole row is nonzero, so the OR selects the back word.
// Depends on dq_pkg.
`default_nettype none

module dq_group_or #(
	parameter int LANES = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic [LANES-1:0][dq_pkg::WORD_W-1:0] taps,
	output logic      [dq_pkg::WORD_W-1:0]            merged_q
);

	logic [dq_pkg::WORD_W-1:0] merged_d;

	// OR of the independent taps of this group.
	always_comb begin
		merged_d = '0;
		for (int i = 0; i < LANES; i++) begin
			merged_d = merged_d | taps[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			merged_q <= merged_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words held in a row of DEPTH cells, front
// word in the first cell. A command transaction updates the whole row in the cycle it is
// accepted. The result transaction is registered once the back word has been found by a
// two-level OR over the cells' back taps (registered groups of 32 cells, then the group
// registers); it waits while the output register still holds an untaken result. A new command
// is taken once the previous result has reached the output register. A push into a full
// queue is dropped and flagged as overflow; a pop from an empty queue returns popped_valid
// low. Command codes above peek act as a peek.
// Depends on dq_pkg, dq_cell and dq_group_or.
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire dq_pkg::dq_in_t cmd,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output dq_pkg::dq_out_t     rsp
);

	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int NUM_GROUPS = (DEPTH + dq_pkg::GROUP_SIZE - 1) / dq_pkg::GROUP_SIZE;

	logic [DEPTH-1:0][dq_pkg::WORD_W-1:0]      cell_data;
	logic [DEPTH-1:0]                          cell_valid;
	logic [DEPTH-1:0][dq_pkg::WORD_W-1:0]      cell_tap;
	logic [NUM_GROUPS-1:0][dq_pkg::WORD_W-1:0] group_q;

	dq_pkg::cell_ctrl_t        ctrl;
	dq_pkg::cmd_t              op;
	logic                      accept;
	logic                      is_push;
	logic                      is_pop;
	logic                      full;
	logic                      empty;
	logic                      advance;
	logic [dq_pkg::WORD_W-1:0] back_merged;

	logic [CNT_W-1:0]          count_q;
	logic                      s1_valid_q;
	logic                      s2_valid_q;
	logic                      rsp_valid_q;
	dq_pkg::dq_out_t           rsp_q;

	logic [dq_pkg::WORD_W-1:0] popped_s1;
	logic                      popped_ok_s1;
	logic                      overflow_s1;
	logic [dq_pkg::WORD_W-1:0] popped_s2;
	logic                      popped_ok_s2;
	logic                      overflow_s2;

	// Command decode and the queue-level guards.
	assign op        = dq_pkg::cmd_t'(cmd.command);
	assign cmd_ready = !s1_valid_q && !s2_valid_q;
	assign accept    = cmd_valid && cmd_ready;
	assign is_push   = (op == dq_pkg::CMD_PUSH_FRONT) || (op == dq_pkg::CMD_PUSH_BACK);
	assign is_pop    = (op == dq_pkg::CMD_POP_FRONT) || (op == dq_pkg::CMD_POP_BACK);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign ctrl.en   = accept && ((is_push && !full) || (is_pop && !empty));
	assign ctrl.op   = op;

	// The row of cells; the ends see a permanent neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [dq_pkg::WORD_W-1:0] prev_data;
		logic                      prev_valid;
		logic [dq_pkg::WORD_W-1:0] next_data;
		logic                      next_valid;

		if (i == 0) begin : g_first
			assign prev_data  = cmd.push_value;
			assign prev_valid = 1'b1;
		end else begin : g_inner_prev
			assign prev_data  = cell_data[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_data  = '0;
			assign next_valid = 1'b0;
		end else begin : g_inner_next
			assign next_data  = cell_data[i+1];
			assign next_valid = cell_valid[i+1];
		end

		dq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.push_word  (cmd.push_value),
			.prev_data  (prev_data),
			.prev_valid (prev_valid),
			.next_data  (next_data),
			.next_valid (next_valid),
			.data       (cell_data[i]),
			.valid      (cell_valid[i]),
			.tap        (cell_tap[i])
		);
	end

	// First level of the back-value reduction, captured in the cycle after the update.
	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
		localparam int BASE  = g * dq_pkg::GROUP_SIZE;
		localparam int LANES = (DEPTH - BASE < dq_pkg::GROUP_SIZE) ?
			(DEPTH - BASE) : dq_pkg::GROUP_SIZE;

		dq_group_or #(
			.LANES (LANES)
		) u_group (
			.clk      (clk),
			.en       (s1_valid_q),
			.taps     (cell_tap[BASE +: LANES]),
			.merged_q (group_q[g])
		);
	end

	// Second level of the reduction over the group registers.
	always_comb begin
		back_merged = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			back_merged = back_merged | group_q[g];
		end
	end

	// Stage control: one command in flight, result register parts the two sides.
	assign advance = s2_valid_q && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			if (s1_valid_q) begin
				s2_valid_q <= 1'b1;
			end else if (advance) begin
				s2_valid_q <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (ctrl.en) begin
				if (is_push) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	// Per-command result fields; a pop from the back returns the current back word.
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_ok_s1 <= is_pop && !empty;
			overflow_s1  <= is_push && full;
			if (!is_pop || empty) begin
				popped_s1 <= '0;
			end else if (op == dq_pkg::CMD_POP_FRONT) begin
				popped_s1 <= cell_data[0];
			end else begin
				popped_s1 <= rsp_q.back_value;
			end
		end
		if (s1_valid_q) begin
			popped_s2    <= popped_s1;
			popped_ok_s2 <= popped_ok_s1;
			overflow_s2  <= overflow_s1;
		end
		if (advance) begin
			rsp_q.popped_value <= popped_s2;
			rsp_q.popped_valid <= popped_ok_s2;
			rsp_q.entry_count  <= dq_pkg::COUNT_W'(count_q);
			rsp_q.is_empty     <= empty;
			rsp_q.front_value  <= cell_valid[0] ? cell_data[0] : '0;
			rsp_q.back_value   <= back_merged;
			rsp_q.overflow     <= overflow_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: tb/double_ended_queue_tb.sv
// Self-checking testbench for double_ended_queue: a queue-fed driver, a stalling receiver and
// a checker that predicts every result from its own copy of the deque contents.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 100ps

module double_ended_queue_tb;

	localparam int DEPTH        = 1024;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int PHASE_LEN    = 150;
	localparam int HOLD_START   = 300;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	// Command codes the package leaves unnamed; the block treats them as a peek.
	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            cmd_valid = 1'b0;
	logic            cmd_ready;
	dq_pkg::dq_in_t  cmd       = '0;
	logic            rsp_valid;
	logic            rsp_ready = 1'b0;
	dq_pkg::dq_out_t rsp;

	// Stimulus and scoreboard storage.
	dq_pkg::dq_in_t  pending_items[$];
	dq_pkg::dq_out_t expected_results[$];
	int              total_items    = 0;
	int              sent_count     = 0;
	int              mismatch_count = 0;
	int              gen_count      = 0;

	// Predicted deque contents.
	logic signed [dq_pkg::WORD_W-1:0] model_store[DEPTH];
	logic [IDX_W-1:0]                 model_head  = '0;
	logic [IDX_W-1:0]                 model_tail  = '0;
	int unsigned                      model_count = 0;

	// Long receiver hold-off.
	logic hold_active = 1'b0;
	logic hold_done   = 1'b0;
	int   hold_left   = 0;

	wire [1:0] idle_phase = 2'((sent_count / PHASE_LEN) % 4);

	double_ended_queue #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one command to the predicted deque and returns the result it should give.
	function automatic dq_pkg::dq_out_t deque_apply(dq_pkg::dq_in_t item);
		dq_pkg::dq_out_t  res;
		logic [IDX_W-1:0] last_pos;
		res = '0;
		case (item.command)
			dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
				if (model_count == DEPTH) begin
					res.overflow = 1'b1;
				end else if (item.command == dq_pkg::CMD_PUSH_FRONT) begin
					model_head = (model_head == '0) ? IDX_W'(DEPTH - 1) : model_head - 1'b1;
					model_store[model_head] = item.push_value;
					model_count++;
				end else begin
					model_store[model_tail] = item.push_value;
					model_tail = (model_tail == IDX_W'(DEPTH - 1)) ? '0 : model_tail + 1'b1;
					model_count++;
				end
			end
			dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
				if (model_count != 0) begin
					if (item.command == dq_pkg::CMD_POP_FRONT) begin
						res.popped_value = model_store[model_head];
						model_head = (model_head == IDX_W'(DEPTH - 1)) ? '0 : model_head + 1'b1;
					end else begin
						model_tail = (model_tail == '0) ? IDX_W'(DEPTH - 1) : model_tail - 1'b1;
						res.popped_value = model_store[model_tail];
					end
					res.popped_valid = 1'b1;
					model_count--;
				end
			end
			default: begin
			end
		endcase
		if (model_count != 0) begin
			last_pos        = (model_tail == '0) ? IDX_W'(DEPTH - 1) : model_tail - 1'b1;
			res.front_value = model_store[model_head];
			res.back_value  = model_store[last_pos];
		end
		res.entry_count = dq_pkg::COUNT_W'(model_count);
		res.is_empty    = (model_count == 0);
		return res;
	endfunction

	// Queues one command and tracks how full the deque will be once it has run.
	task automatic queue_item(input logic [2:0] op, input logic [dq_pkg::WORD_W-1:0] value);
		dq_pkg::dq_in_t item;
		item.command    = op;
		item.push_value = value;
		pending_items   = {pending_items, item};
		if ((op == dq_pkg::CMD_PUSH_FRONT || op == dq_pkg::CMD_PUSH_BACK) && gen_count < DEPTH)
			gen_count++;
		else if ((op == dq_pkg::CMD_POP_FRONT || op == dq_pkg::CMD_POP_BACK) && gen_count > 0)
			gen_count--;
	endtask

	// Queues one random command with the given share of pushes and pops.
	task automatic queue_random(input int push_pct, input int pop_pct);
		int         pick;
		logic [2:0] op;
		pick = $urandom_range(99);
		if (pick < push_pct)
			op = $urandom_range(1) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT;
		else if (pick < push_pct + pop_pct)
			op = $urandom_range(1) ? dq_pkg::CMD_POP_BACK : dq_pkg::CMD_POP_FRONT;
		else
			op = 3'($urandom_range(CMD_SPARE_HI, dq_pkg::CMD_PEEK));
		queue_item(op, $urandom);
	endtask

	// Compares one result field and reports the first few mismatches.
	task automatic compare_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	// Command driver: offers the next pending transaction unless the sender idles.
	always @(posedge clk) begin : cmd_driver
		int idle_pct;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_ready) begin
			idle_pct = (idle_phase == 2'd1) ? 66 : (idle_phase == 2'd3) ? 22 : 0;
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cmd_valid <= 1'b1;
				cmd       <= pending_items[0];
				pending_items.delete(0);
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// One long hold-off of the receiver while commands keep coming.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && sent_count >= HOLD_START) begin
				hold_active <= 1'b1;
				hold_done   <= 1'b1;
				hold_left   <= HOLD_CYCLES;
			end else if (hold_active) begin
				if (hold_left == 1)
					hold_active <= 1'b0;
				hold_left <= hold_left - 1;
			end
		end
	end

	// Result receiver with random stalls.
	always @(posedge clk) begin : rsp_receiver
		int stall_pct;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			stall_pct = (idle_phase == 2'd2) ? 66 : (idle_phase == 2'd3) ? 22 : 0;
			rsp_ready <= !hold_active && ($urandom_range(99) >= stall_pct);
		end
	end

	// Predicts each accepted command, then checks each accepted result in order.
	always @(posedge clk) begin : result_check
		dq_pkg::dq_out_t want;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				expected_results = {expected_results, deque_apply(cmd)};
				sent_count <= sent_count + 1;
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("result transaction with none expected: %h", rsp);
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					compare_field("popped_value", 64'(rsp.popped_value), 64'(want.popped_value));
					compare_field("popped_valid", 64'(rsp.popped_valid), 64'(want.popped_valid));
					compare_field("entry_count", 64'(rsp.entry_count), 64'(want.entry_count));
					compare_field("is_empty", 64'(rsp.is_empty), 64'(want.is_empty));
					compare_field("front_value", 64'(rsp.front_value), 64'(want.front_value));
					compare_field("back_value", 64'(rsp.back_value), 64'(want.back_value));
					compare_field("overflow", 64'(rsp.overflow), 64'(want.overflow));
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		// Empty deque: both pops, peek and the spare codes.
		queue_item(dq_pkg::CMD_POP_FRONT, $urandom);
		queue_item(dq_pkg::CMD_POP_BACK, $urandom);
		queue_item(dq_pkg::CMD_PEEK, $urandom);
		queue_item(CMD_SPARE_LO, $urandom);
		queue_item(CMD_SPARE_MID, $urandom);
		queue_item(CMD_SPARE_HI, $urandom);
		// Extreme words at both ends.
		queue_item(dq_pkg::CMD_PUSH_BACK, 32'h7fff_ffff);
		queue_item(dq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
		queue_item(dq_pkg::CMD_PUSH_BACK, 32'h0000_0000);
		queue_item(dq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff);
		queue_item(dq_pkg::CMD_PEEK, $urandom);
		queue_item(dq_pkg::CMD_PUSH_BACK, 32'h5555_5555);
		queue_item(dq_pkg::CMD_PUSH_FRONT, 32'haaaa_aaaa);
		// Drain from both ends, then pop once more on empty.
		queue_item(dq_pkg::CMD_POP_BACK, $urandom);
		queue_item(dq_pkg::CMD_POP_FRONT, $urandom);
		queue_item(dq_pkg::CMD_POP_FRONT, $urandom);
		queue_item(dq_pkg::CMD_POP_BACK, $urandom);
		queue_item(dq_pkg::CMD_POP_BACK, $urandom);
		queue_item(dq_pkg::CMD_POP_FRONT, $urandom);
		queue_item(dq_pkg::CMD_POP_FRONT, $urandom);
		// A single word taken from the opposite end it went in.
		queue_item(dq_pkg::CMD_PUSH_FRONT, $urandom);
		queue_item(dq_pkg::CMD_POP_BACK, $urandom);
		queue_item(dq_pkg::CMD_PUSH_BACK, $urandom);
		queue_item(dq_pkg::CMD_POP_FRONT, $urandom);

		// Balanced mix around empty.
		repeat (100) queue_random(45, 40);
		// Fill to capacity, then churn while full so that pushes overflow.
		while (gen_count < DEPTH) queue_random(97, 2);
		repeat (60) queue_random(60, 30);
		// Mostly pops back down from full.
		repeat (100) queue_random(20, 70);
		total_items = pending_items.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_count != total_items) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("double_ended_queue_tb OK");
		else
			$display("double_ended_queue_tb NOT OK");
		$finish;
	end

	// Watchdog for a run that hangs.
	initial begin
		#2_000_000;
		$display("double_ended_queue_tb NOT OK");
		$finish;
	end

endmodule
